// ===== design/vpd_ks_pkg.sv =====
// Package for the VPD keyword resource scanner: field widths, character
// constants, walk phase and register codes, the result struct.
// No dependencies.
package vpd_ks_pkg;

  localparam int DEFAULT_MAX_SECTION_BYTES = 1024;
  localparam int OUT_W     = 11;
  localparam int HDR_BYTES = 3;

  localparam logic [7:0] CHAR_0  = 8'h30;
  localparam logic [7:0] CHAR_9  = 8'h39;
  localparam logic [7:0] CHAR_A  = 8'h41;
  localparam logic [7:0] CHAR_Z  = 8'h5A;
  localparam logic [7:0] CHAR_US = 8'h5F;

  typedef enum logic [1:0] {
    PH_KW1,
    PH_KW2,
    PH_LEN,
    PH_DATA
  } phase_t;

  typedef enum logic [1:0] {
    REG_FIRST_CHAR  = 2'd0,
    REG_SECOND_CHAR = 2'd1,
    REG_KW_LENGTH   = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [7:0] first_char;
    logic [7:0] second_char;
    logic [1:0] kw_length;
  } kw_cfg_t;

  typedef struct packed {
    logic             found;
    logic [OUT_W-1:0] resource_offset;
    logic [OUT_W-1:0] used_length;
    logic             overflow;
  } result_t;

  function automatic logic valid_char(input logic [7:0] c);
    return c inside {[CHAR_0:CHAR_9], [CHAR_A:CHAR_Z], CHAR_US};
  endfunction

endpackage

// ===== design/vpd_ks_section_if.sv =====
// Input channel of the scanner: one section byte per beat.
// No dependencies.
interface vpd_ks_section_if;
  logic       valid;
  logic       ready;
  logic [7:0] section_byte;
  logic       last_byte;

  modport source(output valid, section_byte, last_byte, input ready);
  modport sink(input valid, section_byte, last_byte, output ready);
endinterface

// ===== design/vpd_ks_report_if.sv =====
// Output channel of the scanner: one report beat per section.
// Depends on vpd_ks_pkg for the field width.
interface vpd_ks_report_if import vpd_ks_pkg::*;;
  logic             valid;
  logic             ready;
  logic             found;
  logic [OUT_W-1:0] resource_offset;
  logic [OUT_W-1:0] used_length;
  logic             overflow;

  modport source(output valid, found, resource_offset, used_length, overflow, input ready);
  modport sink(input valid, found, resource_offset, used_length, overflow, output ready);
endinterface

// ===== design/vpd_ks_walker.sv =====
// Resource chain walker: scan state and its per-byte update, plus the
// report built from the updated state. Depends on vpd_ks_pkg.
module vpd_ks_walker import vpd_ks_pkg::*; #(
  parameter int MAX_SECTION_BYTES = DEFAULT_MAX_SECTION_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data,
  input  logic       last,
  input  kw_cfg_t    cfg,
  output result_t    result
);

  localparam int POS_W = $clog2(MAX_SECTION_BYTES + 1);
  localparam logic [POS_W-1:0] MAX_POS   = POS_W'(MAX_SECTION_BYTES);
  localparam logic [POS_W-1:0] FIRST_RES = POS_W'(HDR_BYTES);

  logic [POS_W-1:0] position, position_scan, position_next;
  logic [POS_W-1:0] resource_start, resource_start_scan, resource_start_next;
  phase_t           phase, phase_scan, phase_next;
  logic [7:0]       data_remaining, data_remaining_scan, data_remaining_next;
  logic             walk_stopped, walk_stopped_scan, walk_stopped_next;
  logic             keyword_matches, keyword_matches_scan, keyword_matches_next;
  logic             match_seen, match_seen_scan, match_seen_next;
  logic [POS_W-1:0] match_offset, match_offset_scan, match_offset_next;
  logic [POS_W-1:0] chain_length, chain_length_scan, chain_length_next;
  logic             size_exceeded, size_exceeded_scan, size_exceeded_next;
  logic             finish;

  // effect of this byte on the scan state
  always_comb begin
    position_scan        = position;
    resource_start_scan  = resource_start;
    phase_scan           = phase;
    data_remaining_scan  = data_remaining;
    walk_stopped_scan    = walk_stopped;
    keyword_matches_scan = keyword_matches;
    match_seen_scan      = match_seen;
    match_offset_scan    = match_offset;
    chain_length_scan    = chain_length;
    size_exceeded_scan   = size_exceeded;
    finish               = 1'b0;
    if (position >= MAX_POS) begin
      size_exceeded_scan = 1'b1;
    end else begin
      position_scan = position + POS_W'(1);
      if (position >= FIRST_RES && !walk_stopped) begin
        case (phase)
          PH_KW1: begin
            if (!valid_char(data)) begin
              walk_stopped_scan = 1'b1;
            end else begin
              keyword_matches_scan = (cfg.kw_length == 2'd0) || (data == cfg.first_char);
              phase_scan = PH_KW2;
            end
          end
          PH_KW2: begin
            if (!valid_char(data)) begin
              walk_stopped_scan = 1'b1;
            end else begin
              // kw_length of two or three compares both characters
              if (cfg.kw_length[1] && data != cfg.second_char) begin
                keyword_matches_scan = 1'b0;
              end
              phase_scan = PH_LEN;
            end
          end
          PH_LEN: begin
            if (data == 8'd0) begin
              finish = 1'b1;
            end else begin
              data_remaining_scan = data;
              phase_scan = PH_DATA;
            end
          end
          PH_DATA: begin
            data_remaining_scan = data_remaining - 8'd1;
            if (data_remaining == 8'd1) begin
              finish = 1'b1;
            end
          end
          default: ;
        endcase
        if (finish) begin
          chain_length_scan = position + POS_W'(1);
          if (keyword_matches && !match_seen) begin
            match_seen_scan   = 1'b1;
            match_offset_scan = resource_start;
          end
          resource_start_scan = position + POS_W'(1);
          phase_scan = PH_KW1;
        end
      end
    end
  end

  // section end returns the scan to its starting values
  always_comb begin
    if (last) begin
      position_next        = '0;
      resource_start_next  = FIRST_RES;
      phase_next           = PH_KW1;
      data_remaining_next  = 8'd0;
      walk_stopped_next    = 1'b0;
      keyword_matches_next = 1'b0;
      match_seen_next      = 1'b0;
      match_offset_next    = '0;
      chain_length_next    = FIRST_RES;
      size_exceeded_next   = 1'b0;
    end else begin
      position_next        = position_scan;
      resource_start_next  = resource_start_scan;
      phase_next           = phase_scan;
      data_remaining_next  = data_remaining_scan;
      walk_stopped_next    = walk_stopped_scan;
      keyword_matches_next = keyword_matches_scan;
      match_seen_next      = match_seen_scan;
      match_offset_next    = match_offset_scan;
      chain_length_next    = chain_length_scan;
      size_exceeded_next   = size_exceeded_scan;
    end
  end

  always_comb begin
    result.found           = match_seen_scan;
    result.resource_offset = match_seen_scan ? OUT_W'(match_offset_scan) : '0;
    result.used_length     = OUT_W'(chain_length_scan);
    result.overflow        = size_exceeded_scan;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position        <= '0;
      resource_start  <= FIRST_RES;
      phase           <= PH_KW1;
      data_remaining  <= 8'd0;
      walk_stopped    <= 1'b0;
      keyword_matches <= 1'b0;
      match_seen      <= 1'b0;
      match_offset    <= '0;
      chain_length    <= FIRST_RES;
      size_exceeded   <= 1'b0;
    end else if (step) begin
      position        <= position_next;
      resource_start  <= resource_start_next;
      phase           <= phase_next;
      data_remaining  <= data_remaining_next;
      walk_stopped    <= walk_stopped_next;
      keyword_matches <= keyword_matches_next;
      match_seen      <= match_seen_next;
      match_offset    <= match_offset_next;
      chain_length    <= chain_length_next;
      size_exceeded   <= size_exceeded_next;
    end
  end

endmodule

// ===== design/vpd_ks_result_reg.sv =====
// Report output register: holds one report until the sink takes it.
// Depends on vpd_ks_pkg for result_t.
module vpd_ks_result_reg import vpd_ks_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t result_in,
  input  logic    ready,
  output logic    valid,
  output result_t result_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

// ===== design/vpd_keyword_resource_scanner.sv =====
// VPD keyword resource scanner. Throughput: one section byte per cycle,
// unless a last byte is held back. A last byte passes the input register
// and its report the report register. The last byte waits in the input
// register only while the previous report has not been taken.
// Reset (synchronous, active high) clears the scan state, empties both
// registers and sets the keyword registers to 0, 0 and length 2.
module vpd_keyword_resource_scanner import vpd_ks_pkg::*; #(
  parameter int MAX_SECTION_BYTES = DEFAULT_MAX_SECTION_BYTES
) (
  input  logic             clk,
  input  logic             rst,
  vpd_ks_section_if.sink   section,
  vpd_ks_report_if.source  report,
  input  logic             write_enable,
  input  logic [1:0]       reg_index,
  input  logic [7:0]       write_data
);

  kw_cfg_t    cfg;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       advance;
  result_t    walk_result;
  result_t    held_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_char  <= 8'd0;
      cfg.second_char <= 8'd0;
      cfg.kw_length   <= 2'd2;
    end else if (write_enable) begin
      case (reg_index)
        REG_FIRST_CHAR:  cfg.first_char  <= write_data;
        REG_SECOND_CHAR: cfg.second_char <= write_data;
        REG_KW_LENGTH:   cfg.kw_length   <= write_data[1:0];
        default: ;
      endcase
    end
  end

  // only a last byte needs the report slot
  assign advance       = in_valid && (!in_last || !report.valid || report.ready);
  assign section.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (section.ready) begin
      in_valid <= section.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (section.valid && section.ready) begin
      in_byte <= section.section_byte;
      in_last <= section.last_byte;
    end
  end

  vpd_ks_walker #(.MAX_SECTION_BYTES(MAX_SECTION_BYTES)) u_walker (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .data   (in_byte),
    .last   (in_last),
    .cfg    (cfg),
    .result (walk_result)
  );

  vpd_ks_result_reg u_result (
    .clk        (clk),
    .rst        (rst),
    .load       (advance && in_last),
    .result_in  (walk_result),
    .ready      (report.ready),
    .valid      (report.valid),
    .result_out (held_result)
  );

  assign report.found           = held_result.found;
  assign report.resource_offset = held_result.resource_offset;
  assign report.used_length     = held_result.used_length;
  assign report.overflow        = held_result.overflow;

endmodule

// ===== design/vpd_ks_checker.sv =====
// Port-level checks for the VPD keyword resource scanner, bound to the top.
// Depends on vpd_ks_pkg and on the top level's channel interfaces.
module vpd_ks_checker import vpd_ks_pkg::*; #(
  parameter int MAX_SECTION_BYTES = DEFAULT_MAX_SECTION_BYTES
) (
  input logic             clk,
  input logic             rst,
  input logic             section_ready,
  input logic             report_valid,
  input logic             report_ready,
  input logic             found,
  input logic [OUT_W-1:0] resource_offset,
  input logic [OUT_W-1:0] used_length,
  input logic             overflow
);

  localparam logic WRAPS = (MAX_SECTION_BYTES >= (1 << OUT_W));

  a_reset_empty: assert property (@(posedge clk) rst |=> !report_valid)
    else $error("report valid right after reset");

  a_report_holds: assert property (@(posedge clk) disable iff (rst)
    report_valid && !report_ready |=> report_valid && $stable(found)
      && $stable(resource_offset) && $stable(used_length) && $stable(overflow))
    else $error("stalled report changed");

  // with the report slot empty no byte is ever held back
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !report_valid |-> section_ready)
    else $error("input stalled while report slot empty");

  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    report_valid && !found |-> resource_offset == '0)
    else $error("offset nonzero without a match");

  a_min_length: assert property (@(posedge clk) disable iff (rst)
    report_valid && !WRAPS |-> used_length >= OUT_W'(HDR_BYTES))
    else $error("used length below header size");

endmodule

bind vpd_keyword_resource_scanner vpd_ks_checker #(
  .MAX_SECTION_BYTES(MAX_SECTION_BYTES)
) u_checker (
  .clk             (clk),
  .rst             (rst),
  .section_ready   (section.ready),
  .report_valid    (report.valid),
  .report_ready    (report.ready),
  .found           (report.found),
  .resource_offset (report.resource_offset),
  .used_length     (report.used_length),
  .overflow        (report.overflow)
);
